// ===== hw/rtl/rpts_pkg.sv =====
// shared types and constants for the priority task scheduler
// no dependencies; used by rpts_ctrl, rpts_datapath and the top level
`timescale 1ns / 1ps

package rpts_pkg;

    localparam logic [2:0] FUNC_CREATE = 3'd0;
    localparam logic [2:0] FUNC_SLEEP  = 3'd1;
    localparam logic [2:0] FUNC_TICK   = 3'd2;
    localparam logic [2:0] FUNC_WAKE   = 3'd3;
    localparam logic [2:0] FUNC_DELETE = 3'd4;
    localparam logic [2:0] FUNC_SWITCH = 3'd5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SLEEP_WR,
        S_WAKE_WR,
        S_TICK_PRIO,
        S_TICK_SCAN,
        S_SEL_START,
        S_SEL_SCAN,
        S_SEL_FIN,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_ERR,
        DP_EW,
        DP_CREATE,
        DP_READ_RUN,
        DP_READ_SLOT,
        DP_SLEEP_WR,
        DP_WAKE_WR,
        DP_DELETE,
        DP_SCAN_START,
        DP_TICK_STEP,
        DP_SEL_STEP,
        DP_SEL_FIN
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        logic   load_out;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       bad;
        logic       sleep_zero;
        logic       del_running;
        logic       scan_last;
        logic       out_stall;
    } dp_status_t;

endpackage

// ===== hw/rtl/rpts_ctrl.sv =====
// command sequencer for the priority task scheduler
// depends on rpts_pkg; drives rpts_datapath through dp_cmd_t
`timescale 1ns / 1ps

module rpts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  rpts_pkg::dp_status_t status,
    output logic                s_tready,
    output rpts_pkg::dp_cmd_t   cmd
);

    rpts_pkg::state_t state_reg;
    rpts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpts_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rpts_pkg::S_DISPATCH;
                end
            end
            rpts_pkg::S_DISPATCH:
            begin
                case (status.func)
                    rpts_pkg::FUNC_SLEEP:
                    begin
                        if (status.bad || status.sleep_zero)
                        begin
                            state_next = rpts_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = rpts_pkg::S_SLEEP_WR;
                        end
                    end
                    rpts_pkg::FUNC_TICK:
                    begin
                        state_next = rpts_pkg::S_TICK_PRIO;
                    end
                    rpts_pkg::FUNC_WAKE:
                    begin
                        state_next = status.bad ? rpts_pkg::S_DONE : rpts_pkg::S_WAKE_WR;
                    end
                    rpts_pkg::FUNC_DELETE:
                    begin
                        if (!status.bad && status.del_running)
                        begin
                            state_next = rpts_pkg::S_SEL_START;
                        end
                        else
                        begin
                            state_next = rpts_pkg::S_DONE;
                        end
                    end
                    rpts_pkg::FUNC_SWITCH:
                    begin
                        state_next = rpts_pkg::S_SEL_START;
                    end
                    default:
                    begin
                        state_next = rpts_pkg::S_DONE;
                    end
                endcase
            end
            rpts_pkg::S_SLEEP_WR:
            begin
                state_next = rpts_pkg::S_DONE;
            end
            rpts_pkg::S_WAKE_WR:
            begin
                state_next = rpts_pkg::S_DONE;
            end
            rpts_pkg::S_TICK_PRIO:
            begin
                state_next = rpts_pkg::S_TICK_SCAN;
            end
            rpts_pkg::S_TICK_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = rpts_pkg::S_DONE;
                end
            end
            rpts_pkg::S_SEL_START:
            begin
                state_next = rpts_pkg::S_SEL_SCAN;
            end
            rpts_pkg::S_SEL_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = rpts_pkg::S_SEL_FIN;
                end
            end
            rpts_pkg::S_SEL_FIN:
            begin
                state_next = rpts_pkg::S_DONE;
            end
            rpts_pkg::S_DONE:
            begin
                if (!status.out_stall)
                begin
                    state_next = rpts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.op       = rpts_pkg::DP_NONE;
        case (state_reg)
            rpts_pkg::S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            rpts_pkg::S_DISPATCH:
            begin
                case (status.func)
                    rpts_pkg::FUNC_CREATE:
                    begin
                        cmd.op = status.bad ? rpts_pkg::DP_ERR : rpts_pkg::DP_CREATE;
                    end
                    rpts_pkg::FUNC_SLEEP:
                    begin
                        if (status.bad)
                        begin
                            cmd.op = rpts_pkg::DP_ERR;
                        end
                        else if (status.sleep_zero)
                        begin
                            cmd.op = rpts_pkg::DP_EW;
                        end
                        else
                        begin
                            cmd.op = rpts_pkg::DP_READ_RUN;
                        end
                    end
                    rpts_pkg::FUNC_TICK:
                    begin
                        cmd.op = rpts_pkg::DP_READ_RUN;
                    end
                    rpts_pkg::FUNC_WAKE:
                    begin
                        cmd.op = status.bad ? rpts_pkg::DP_ERR : rpts_pkg::DP_READ_SLOT;
                    end
                    rpts_pkg::FUNC_DELETE:
                    begin
                        cmd.op = status.bad ? rpts_pkg::DP_ERR : rpts_pkg::DP_DELETE;
                    end
                    default:
                    begin
                        cmd.op = rpts_pkg::DP_NONE;
                    end
                endcase
            end
            rpts_pkg::S_SLEEP_WR:
            begin
                cmd.op = rpts_pkg::DP_SLEEP_WR;
            end
            rpts_pkg::S_WAKE_WR:
            begin
                cmd.op = rpts_pkg::DP_WAKE_WR;
            end
            rpts_pkg::S_TICK_PRIO:
            begin
                cmd.op = rpts_pkg::DP_SCAN_START;
            end
            rpts_pkg::S_TICK_SCAN:
            begin
                cmd.op = rpts_pkg::DP_TICK_STEP;
            end
            rpts_pkg::S_SEL_START:
            begin
                cmd.op = rpts_pkg::DP_SCAN_START;
            end
            rpts_pkg::S_SEL_SCAN:
            begin
                cmd.op = rpts_pkg::DP_SEL_STEP;
            end
            rpts_pkg::S_SEL_FIN:
            begin
                cmd.op = rpts_pkg::DP_SEL_FIN;
            end
            rpts_pkg::S_DONE:
            begin
                cmd.load_out = !status.out_stall;
            end
            default:
            begin
                cmd.op = rpts_pkg::DP_NONE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rpts_datapath.sv =====
// slot table, running slot, scan registers and result register of the scheduler
// depends on rpts_pkg; sequenced by rpts_ctrl
`timescale 1ns / 1ps

module rpts_datapath
#(
    parameter int MAX_TASKS     = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TICK_BITS     = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rpts_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             m_tready,
    input  rpts_pkg::dp_cmd_t                cmd,
    output logic                             m_tvalid,
    output logic [rpts_pkg::OUT_DATA_W-1:0]  m_tdata,
    output rpts_pkg::dp_status_t             status
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_TASKS - 1);

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic                     blocked;
        logic [TICK_BITS-1:0]     ticks;
        logic                     ew;
    } entry_t;

    entry_t mem [MAX_TASKS];
    entry_t rdata_reg;

    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    entry_t                mem_wdata;
    logic [SLOT_W-1:0]     mem_raddr;

    logic [2:0]               func_reg,     func_next;
    logic [3:0]               slot_reg,     slot_next;
    logic [PRIORITY_BITS-1:0] prio_reg,     prio_next;
    logic [TICK_BITS-1:0]     ticks_reg,    ticks_next;
    logic [MAX_TASKS-1:0]     valid_reg,    valid_next;
    logic [SLOT_W-1:0]        run_reg,      run_next;
    logic [SLOT_W-1:0]        idx_reg,      idx_next;
    logic [PRIORITY_BITS-1:0] cur_prio_reg, cur_prio_next;
    logic                     found_reg,    found_next;
    logic [SLOT_W-1:0]        best_idx_reg, best_idx_next;
    entry_t                   best_ent_reg, best_ent_next;
    logic                     sw_reg,       sw_next;
    logic                     hi_reg,       hi_next;
    logic                     ew_reg,       ew_next;
    logic                     err_reg,      err_next;
    logic                     out_valid_reg, out_valid_next;
    logic [rpts_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                     boot_reg;

    logic              in_range;
    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] scan_next_idx;
    logic              ent_valid;
    logic              ent_ready;
    logic              scan_last;

    assign slot_idx      = SLOT_W'(slot_reg);
    assign in_range      = {28'd0, slot_reg} < 32'(MAX_TASKS);
    assign scan_last     = idx_reg == LAST_IDX;
    assign scan_next_idx = scan_last ? '0 : idx_reg + SLOT_W'(1);
    assign ent_valid     = valid_reg[idx_reg];
    assign ent_ready     = ent_valid && !rdata_reg.blocked && (rdata_reg.ticks == '0);

    always_comb
    begin
        status.func        = func_reg;
        status.sleep_zero  = ticks_reg == '0;
        status.del_running = slot_idx == run_reg;
        status.scan_last   = scan_last;
        status.out_stall   = out_valid_reg && !m_tready;
        case (func_reg)
            rpts_pkg::FUNC_CREATE: status.bad = !in_range || valid_reg[slot_idx];
            rpts_pkg::FUNC_SLEEP:  status.bad = !valid_reg[run_reg];
            rpts_pkg::FUNC_WAKE:   status.bad = !in_range || !valid_reg[slot_idx];
            rpts_pkg::FUNC_DELETE: status.bad = !in_range || !valid_reg[slot_idx];
            default:               status.bad = 1'b0;
        endcase
    end

    always_comb
    begin
        func_next      = func_reg;
        slot_next      = slot_reg;
        prio_next      = prio_reg;
        ticks_next     = ticks_reg;
        valid_next     = valid_reg;
        run_next       = run_reg;
        idx_next       = idx_reg;
        cur_prio_next  = cur_prio_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_ent_next  = best_ent_reg;
        sw_next        = sw_reg;
        hi_next        = hi_reg;
        ew_next        = ew_reg;
        err_next       = err_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rdata_reg;
        mem_raddr      = idx_reg;

        if (cmd.capture)
        begin
            func_next  = s_tdata[2:0];
            slot_next  = s_tdata[6:3];
            prio_next  = PRIORITY_BITS'(s_tdata[14:7]);
            ticks_next = TICK_BITS'(s_tdata[46:15]);
            sw_next    = 1'b0;
            hi_next    = 1'b0;
            ew_next    = 1'b0;
            err_next   = 1'b0;
        end

        case (cmd.op)
            rpts_pkg::DP_ERR:
            begin
                err_next = 1'b1;
            end
            rpts_pkg::DP_EW:
            begin
                ew_next = 1'b1;
            end
            rpts_pkg::DP_CREATE:
            begin
                mem_we               = 1'b1;
                mem_waddr            = slot_idx;
                mem_wdata.prio       = prio_reg;
                mem_wdata.blocked    = 1'b0;
                mem_wdata.ticks      = '0;
                mem_wdata.ew         = 1'b0;
                valid_next[slot_idx] = 1'b1;
            end
            rpts_pkg::DP_READ_RUN:
            begin
                mem_raddr = run_reg;
            end
            rpts_pkg::DP_READ_SLOT:
            begin
                mem_raddr = slot_idx;
            end
            rpts_pkg::DP_SLEEP_WR:
            begin
                mem_we            = 1'b1;
                mem_waddr         = run_reg;
                mem_wdata.blocked = 1'b1;
                mem_wdata.ticks   = ticks_reg;
                mem_wdata.ew      = 1'b0;
            end
            rpts_pkg::DP_WAKE_WR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = slot_idx;
                mem_wdata.ticks = '0;
                mem_wdata.ew    = 1'b1;
            end
            rpts_pkg::DP_DELETE:
            begin
                valid_next[slot_idx] = 1'b0;
            end
            rpts_pkg::DP_SCAN_START:
            begin
                // running task's priority on a tick, zero when its slot is empty
                cur_prio_next = valid_reg[run_reg] ? rdata_reg.prio : '0;
                idx_next      = '0;
                found_next    = 1'b0;
                mem_raddr     = '0;
            end
            rpts_pkg::DP_TICK_STEP:
            begin
                idx_next  = scan_next_idx;
                mem_raddr = scan_next_idx;
                if (ent_valid && rdata_reg.blocked)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    if (rdata_reg.ticks != '0)
                    begin
                        mem_wdata.ticks = rdata_reg.ticks - TICK_BITS'(1);
                    end
                    else
                    begin
                        mem_wdata.blocked = 1'b0;
                        if (rdata_reg.prio >= cur_prio_reg)
                        begin
                            hi_next = 1'b1;
                        end
                    end
                end
            end
            rpts_pkg::DP_SEL_STEP:
            begin
                idx_next  = scan_next_idx;
                mem_raddr = scan_next_idx;
                if (ent_ready && (!found_reg || (rdata_reg.prio > best_ent_reg.prio)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = idx_reg;
                    best_ent_next = rdata_reg;
                end
            end
            rpts_pkg::DP_SEL_FIN:
            begin
                if (found_reg)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = best_idx_reg;
                    mem_wdata    = best_ent_reg;
                    mem_wdata.ew = 1'b0;
                    ew_next      = best_ent_reg.ew;
                    sw_next      = best_idx_reg != run_reg;
                    run_next     = best_idx_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        // idle task record takes its reset value in the first cycle after reset
        if (boot_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {err_reg, ew_reg, hi_reg, sw_reg, 4'(run_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= MAX_TASKS'(1);
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
            boot_reg      <= 1'b1;
        end
        else
        begin
            valid_reg     <= valid_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            boot_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        slot_reg     <= slot_next;
        prio_reg     <= prio_next;
        ticks_reg    <= ticks_next;
        idx_reg      <= idx_next;
        cur_prio_reg <= cur_prio_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_ent_reg <= best_ent_next;
        sw_reg       <= sw_next;
        hi_reg       <= hi_next;
        ew_reg       <= ew_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/rtos_priority_task_scheduler.sv =====
// top level of the fixed-priority task scheduler with tick sleep
// depends on rpts_pkg, rpts_ctrl and rpts_datapath
//
// commands arrive on the s_ channel, one result per command leaves on the m_ channel.
// s_tdata: func, task_slot, task_priority, sleep_ticks from bit 0 up.
// m_tdata: current_slot, switched, higher_awoken, early_wake, error from bit 0 up.
// one command is handled at a time; s_tready is high only while the sequencer idles.
// slot records live in a single-port-read table, so tick and switch visit one slot
// per cycle. tick, switch and delete of the running task scan every slot; sleep of
// nonzero ticks and wake add a record write; create, delete, sleep of zero ticks,
// errors and unknown commands go from dispatch straight to the result.
// the next command can transfer at the edge the result first can.
// the result sits in an output register; while the receiver stalls the next command
// is still taken and worked, and the sequencer then waits until the register drains.
// after reset only slot 0 (idle task, priority 0) is valid and running; its record
// is written in the first cycle after reset, the others need no sweep since
// per-slot valid bits clear at once.
`timescale 1ns / 1ps

module rtos_priority_task_scheduler
#(
    parameter int MAX_TASKS     = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TICK_BITS     = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func[2:0], task_slot[6:3], task_priority[14:7], sleep_ticks[46:15], zero pad
    input  logic [rpts_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // current_slot[3:0], switched[4], higher_awoken[5], early_wake[6], error[7]
    output logic [rpts_pkg::OUT_DATA_W-1:0] m_tdata
);

    rpts_pkg::dp_cmd_t    cmd;
    rpts_pkg::dp_status_t status;

    rpts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rpts_datapath
    #(
        .MAX_TASKS     (MAX_TASKS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TICK_BITS     (TICK_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .status   (status)
    );

endmodule
